// ===== hdl/fhkv_pkg.sv =====
// Shared constants, state and status codes of the FNV-hashed key/value cache.
package fhkv_pkg;

    localparam int DEF_SLOTS         = 16;
    localparam int DEF_MAX_KEY_BYTES = 64;
    localparam int DEF_VALUE_BITS    = 32;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Steps taken to reduce a hash modulo the slot count: a fold of the hash
    // bytes, then a reciprocal multiplication.
    localparam int MOD_STEPS = 2;

    typedef enum logic [2:0] {
        STATUS_HIT        = 3'd0,
        STATUS_MISS       = 3'd1,
        STATUS_INSERTED   = 3'd2,
        STATUS_PRESENT    = 3'd3,
        STATUS_OVERWROTE  = 3'd4,
        STATUS_TOO_LONG   = 3'd5,
        STATUS_NULL_VALUE = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_META,
        ST_CHECK,
        ST_CMP,
        ST_COPY,
        ST_OUT
    } state_t;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

endpackage

// ===== hdl/fhkv_req_if.sv =====
// Request channel carrying one key byte with its command and value handle.
interface fhkv_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  key_byte;
    logic        last;
    logic [31:0] value;

    modport source (output valid, command, key_byte, last, value, input ready);
    modport sink   (input valid, command, key_byte, last, value, output ready);
endinterface

// ===== hdl/fhkv_rsp_if.sv =====
// Result channel carrying the status, found handle and slot of one operation.
interface fhkv_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] found_value;
    logic [3:0]  slot_index;

    modport source (output valid, status, found_value, slot_index, input ready);
    modport sink   (input valid, status, found_value, slot_index, output ready);
endinterface

// ===== hdl/fnv_hashed_key_value_cache_unit.sv =====
// Top level of the FNV-1a hashed key/value cache with linear probing.
//
// Use: key bytes enter on the req channel, one per request. Each byte updates a
// 32-bit FNV-1a hash and is kept in a key buffer. The request with last set
// carries the command (lookup or insert) and the value handle and starts the
// operation; it yields exactly one result on the rsp channel. Other requests
// yield nothing.
// Sequence: a final byte first reduces the hash modulo SLOTS (a fold of the
// hash bytes, then a reciprocal multiplication), then reads the metadata
// memory for each probed slot, and compares the key bytes one a cycle for
// each candidate whose hash and length match; an insert into a free or
// reused slot then copies the key. The result then waits in the output
// register. Over-long keys and null values answer in the cycle after their
// final byte.
// Throughput: one operation at a time; bytes of the next key are taken while
// a result waits, and a final byte is taken as the waiting result leaves.
// Reset clears the slot valid flags at once, so the table is empty, and
// restores the hash, byte count and overflow flag. When the receiver stalls
// the result holds and no new final byte is taken.
module fnv_hashed_key_value_cache_unit
    import fhkv_pkg::*;
#(
    parameter int SLOTS         = DEF_SLOTS,
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES,
    parameter int VALUE_BITS    = DEF_VALUE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    fhkv_req_if.sink    req,
    fhkv_rsp_if.source  rsp
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KB_AW  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_DEPTH = SLOTS * MAX_KEY_BYTES;
    localparam int KA_W   = $clog2(KEY_DEPTH);
    localparam int VW     = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int META_W = 32 + CNT_W + VW;

    // Modulo reduction constants: byte weights modulo SLOTS and a reciprocal
    // that is exact for every folded value below 2**FOLD_W.
    localparam int FOLD_W   = 18;
    localparam int RECIP_W  = FOLD_W + 2;
    localparam int RECIP_SH = FOLD_W + SLOT_W;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << RECIP_SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];
    localparam logic [15:0] W1 = 16'(256 % SLOTS);
    localparam logic [15:0] W2 = 16'(65536 % SLOTS);
    localparam logic [15:0] W3 = 16'(16777216 % SLOTS);

    state_t state_reg, state_next;

    logic [31:0]       acc_reg, acc_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [31:0]       h_reg, h_next;
    logic [FOLD_W-1:0] fold_reg, fold_next;
    logic [2:0]        mod_cnt_reg, mod_cnt_next;
    logic              cmd_reg, cmd_next;
    logic [VW-1:0]     val_reg, val_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] home_reg, home_next;
    logic [SLOT_W-1:0] probes_reg, probes_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  widx_reg, widx_next;
    logic              pend_reg, pend_next;
    logic              mism_reg, mism_next;
    logic [SLOT_W-1:0] target_reg, target_next;
    status_t           status_reg, status_next;
    logic [VW-1:0]     found_reg, found_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;

    // Memory ports.
    logic              kbuf_we;
    logic [KB_AW-1:0]  kbuf_waddr, kbuf_raddr;
    logic [7:0]        kbuf_rdata;
    logic              key_we;
    logic [KA_W-1:0]   key_waddr, key_raddr;
    logic [7:0]        key_rdata;
    logic              meta_we;
    logic [SLOT_W-1:0] meta_raddr;
    logic [META_W-1:0] meta_wdata, meta_rdata;

    logic [31:0]       m_hash;
    logic [CNT_W-1:0]  m_len;
    logic [VW-1:0]     m_val;

    logic              accept, accept_last, room;
    logic [31:0]       hash_new, h_final;
    logic [CNT_W-1:0]  count_inc;
    logic              ovf_new;
    logic [VW-1:0]     val_in;
    logic [FOLD_W-1:0] fold_sum;
    logic [SLOT_W-1:0] rem_red;
    logic              exhausted, cand, cmp_done;
    logic [SLOT_W-1:0] slot_wrap;
    logic [31:0]       slot_wide;

    assign {m_hash, m_len, m_val} = meta_rdata;

    // Incoming byte arithmetic: FNV-1a step and byte count.
    always_comb
    begin
        accept      = req.valid && req.ready;
        accept_last = accept && req.last;
        hash_new    = (acc_reg ^ {24'b0, req.key_byte}) * FNV_PRIME;
        h_final     = (hash_new == 32'd0) ? 32'd1 : hash_new;
        room        = count_reg < CNT_W'(MAX_KEY_BYTES);
        count_inc   = room ? count_reg + CNT_W'(1) : count_reg;
        ovf_new     = ovf_reg || !room;
        val_in      = req.value[VW-1:0];
    end

    // Hash modulo SLOTS: fold the bytes by their weights, then divide the
    // folded value by a reciprocal multiplication.
    always_comb
    begin
        logic [FOLD_W+RECIP_W-1:0] prod;
        logic [FOLD_W-1:0] quot;
        logic [FOLD_W-1:0] left;
        fold_sum = FOLD_W'(h_reg[7:0])
                 + FOLD_W'(16'(h_reg[15:8]) * W1)
                 + FOLD_W'(16'(h_reg[23:16]) * W2)
                 + FOLD_W'(16'(h_reg[31:24]) * W3);
        prod     = (FOLD_W+RECIP_W)'(fold_reg) * (FOLD_W+RECIP_W)'(RECIP);
        quot     = FOLD_W'(prod >> RECIP_SH);
        left     = fold_reg - FOLD_W'(quot * FOLD_W'(SLOTS));
        rem_red  = left[SLOT_W-1:0];
    end

    // Probe bookkeeping.
    always_comb
    begin
        exhausted = probes_reg == SLOT_W'(SLOTS - 1);
        slot_wrap = (slot_reg == SLOT_W'(SLOTS - 1)) ? '0 : slot_reg + SLOT_W'(1);
        cand      = valid_reg[slot_reg] && (m_hash == h_reg) && (m_len == len_reg);
        cmp_done  = (idx_reg == len_reg) && !pend_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_OUT:
            begin
                if (state_reg == ST_OUT && rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
                if (accept_last)
                begin
                    if (ovf_new || (req.command == CMD_INSERT && val_in == '0))
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_MOD;
                    end
                end
            end
            ST_MOD:
            begin
                if (mod_cnt_reg == 3'(MOD_STEPS - 1))
                begin
                    state_next = ST_META;
                end
            end
            ST_META:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!valid_reg[slot_reg])
                begin
                    state_next = (cmd_reg == CMD_INSERT) ? ST_COPY : ST_OUT;
                end
                else if (cand)
                begin
                    state_next = ST_CMP;
                end
                else if (exhausted)
                begin
                    state_next = (cmd_reg == CMD_INSERT) ? ST_COPY : ST_OUT;
                end
                else
                begin
                    state_next = ST_META;
                end
            end
            ST_CMP:
            begin
                if (cmp_done)
                begin
                    if (!mism_reg || exhausted)
                    begin
                        state_next = (!mism_reg || cmd_reg == CMD_LOOKUP) ? ST_OUT : ST_COPY;
                    end
                    else
                    begin
                        state_next = ST_META;
                    end
                end
            end
            ST_COPY:
            begin
                if (cmp_done)
                begin
                    state_next = ST_OUT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        acc_next      = acc_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        h_next        = h_reg;
        fold_next     = fold_reg;
        mod_cnt_next  = mod_cnt_reg;
        cmd_next      = cmd_reg;
        val_next      = val_reg;
        len_next      = len_reg;
        slot_next     = slot_reg;
        home_next     = home_reg;
        probes_next   = probes_reg;
        idx_next      = idx_reg;
        widx_next     = widx_reg;
        pend_next     = 1'b0;
        mism_next     = mism_reg;
        target_next   = target_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        res_slot_next = res_slot_reg;
        valid_next    = valid_reg;

        // Byte accumulation; a final byte restarts the accumulator.
        if (accept)
        begin
            if (req.last)
            begin
                acc_next      = FNV_BASIS;
                count_next    = '0;
                ovf_next      = 1'b0;
                h_next        = h_final;
                mod_cnt_next  = '0;
                cmd_next      = req.command;
                val_next      = val_in;
                len_next      = count_inc;
                found_next    = '0;
                res_slot_next = '0;
                if (ovf_new)
                begin
                    status_next = STATUS_TOO_LONG;
                end
                else if (req.command == CMD_INSERT && val_in == '0)
                begin
                    status_next = STATUS_NULL_VALUE;
                end
            end
            else
            begin
                acc_next   = hash_new;
                count_next = count_inc;
                ovf_next   = ovf_new;
            end
        end

        case (state_reg)
            ST_MOD:
            begin
                fold_next    = fold_sum;
                mod_cnt_next = mod_cnt_reg + 3'd1;
                home_next    = rem_red;
                slot_next    = rem_red;
                probes_next  = '0;
            end
            ST_CHECK:
            begin
                idx_next  = '0;
                mism_next = 1'b0;
                if (!valid_reg[slot_reg])
                begin
                    target_next   = slot_reg;
                    res_slot_next = (cmd_reg == CMD_INSERT) ? slot_reg : '0;
                    status_next   = (cmd_reg == CMD_INSERT) ? STATUS_INSERTED : STATUS_MISS;
                end
                else if (cand)
                begin
                    found_next = m_val;
                end
                else if (exhausted)
                begin
                    target_next   = home_reg;
                    res_slot_next = (cmd_reg == CMD_INSERT) ? home_reg : '0;
                    status_next   = (cmd_reg == CMD_INSERT) ? STATUS_OVERWROTE : STATUS_MISS;
                end
                else
                begin
                    probes_next = probes_reg + SLOT_W'(1);
                    slot_next   = slot_wrap;
                end
            end
            ST_CMP:
            begin
                if (idx_reg < len_reg)
                begin
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg && kbuf_rdata != key_rdata)
                begin
                    mism_next = 1'b1;
                end
                if (cmp_done)
                begin
                    idx_next = '0;
                    if (!mism_reg)
                    begin
                        res_slot_next = slot_reg;
                        target_next   = slot_reg;
                        if (cmd_reg == CMD_LOOKUP)
                        begin
                            status_next = STATUS_HIT;
                        end
                        else
                        begin
                            status_next = STATUS_PRESENT;
                            found_next  = '0;
                        end
                    end
                    else if (exhausted)
                    begin
                        found_next    = '0;
                        target_next   = home_reg;
                        res_slot_next = (cmd_reg == CMD_INSERT) ? home_reg : '0;
                        status_next   = (cmd_reg == CMD_INSERT) ? STATUS_OVERWROTE : STATUS_MISS;
                    end
                    else
                    begin
                        found_next  = '0;
                        probes_next = probes_reg + SLOT_W'(1);
                        slot_next   = slot_wrap;
                    end
                end
            end
            ST_COPY:
            begin
                found_next = '0;
                if (idx_reg < len_reg)
                begin
                    idx_next  = idx_reg + CNT_W'(1);
                    widx_next = idx_reg;
                    pend_next = 1'b1;
                end
                if (cmp_done)
                begin
                    valid_next[target_reg] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Handshakes and memory controls.
    always_comb
    begin
        req.ready       = (state_reg == ST_IDLE)
                       || (state_reg == ST_OUT && (rsp.ready || !req.last));
        rsp.valid       = state_reg == ST_OUT;
        rsp.status      = status_reg;
        rsp.found_value = 32'(found_reg);
        slot_wide       = 32'(res_slot_reg);
        rsp.slot_index  = slot_wide[3:0];

        kbuf_we    = accept && room;
        kbuf_waddr = count_reg[KB_AW-1:0];
        kbuf_raddr = idx_reg[KB_AW-1:0];

        key_raddr  = KA_W'(32'(slot_reg) * MAX_KEY_BYTES + 32'(idx_reg));
        key_we     = (state_reg == ST_COPY) && pend_reg;
        key_waddr  = KA_W'(32'(target_reg) * MAX_KEY_BYTES + 32'(widx_reg));

        meta_raddr = slot_reg;
        meta_we    = (state_reg == ST_COPY) && cmp_done;
        meta_wdata = {h_reg, len_reg, val_reg};
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= FNV_BASIS;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        h_reg        <= h_next;
        fold_reg     <= fold_next;
        mod_cnt_reg  <= mod_cnt_next;
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        len_reg      <= len_next;
        slot_reg     <= slot_next;
        home_reg     <= home_next;
        probes_reg   <= probes_next;
        idx_reg      <= idx_next;
        widx_reg     <= widx_next;
        mism_reg     <= mism_next;
        target_reg   <= target_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        res_slot_reg <= res_slot_next;
    end

    // Incoming key buffer.
    fhkv_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_kbuf (
        .clk     (clk),
        .wr_en   (kbuf_we),
        .wr_addr (kbuf_waddr),
        .wr_data (req.key_byte),
        .rd_addr (kbuf_raddr),
        .rd_data (kbuf_rdata)
    );

    // Stored key bytes, one row of MAX_KEY_BYTES per slot.
    fhkv_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_keys (
        .clk     (clk),
        .wr_en   (key_we),
        .wr_addr (key_waddr),
        .wr_data (kbuf_rdata),
        .rd_addr (key_raddr),
        .rd_data (key_rdata)
    );

    // Slot metadata: hash, length and value.
    fhkv_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta (
        .clk     (clk),
        .wr_en   (meta_we),
        .wr_addr (target_reg),
        .wr_data (meta_wdata),
        .rd_addr (meta_raddr),
        .rd_data (meta_rdata)
    );

endmodule

// ===== hdl/fhkv_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fhkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
